[hw/rtl/seven_segment_decimal_scan_unit_macros.svh]
// Assertion macros shared by the seven-segment decimal scan unit.
`ifndef SEVEN_SEGMENT_DECIMAL_SCAN_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_DECIMAL_SCAN_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define SSDS_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ssds: same-cycle check failed");
// Check that a condition implies another in the next cycle.
`define SSDS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ssds: next-cycle check failed");
`else
`define SSDS_ASSERT_NOW(label, clk, rst_n, a, b)
`define SSDS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[hw/rtl/ssds_pkg.sv]
// Shared types, constants and the digit pattern table of the scan unit.
`timescale 1ns / 1ps

package ssds_pkg;

    // Display geometry: column 0 is thousands, column 3 is units
    localparam int COLS        = 4;
    localparam int DIGIT_W     = 4;
    localparam int COL_W       = 2;
    localparam int VALUE_W     = 16;
    localparam int SEG_W       = 8;

    // Default depth of the queue between digit extraction and column scan
    localparam int QUEUE_DEPTH = 2;

    // Divide by ten: q = (v * 52429) >> 19, exact for every 16-bit v
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // Leading-zero thresholds for thousands, hundreds and tens
    localparam logic [VALUE_W-1:0] THOUSANDS_MIN = 16'd999;
    localparam logic [VALUE_W-1:0] HUNDREDS_MIN  = 16'd99;
    localparam logic [VALUE_W-1:0] TENS_MIN      = 16'd9;

    localparam logic [COLS-1:0]  ALL_COLUMNS_OFF = 4'hF;
    localparam logic [COL_W-1:0] UNITS_COL       = 2'd3;

    // Decimal digits of one value plus which columns light
    typedef struct packed {
        logic [COLS-1:0][DIGIT_W-1:0] digits;
        logic [COLS-1:0]              lit;
    } t_digit_rec;

    // Active-low seven-segment pattern, decimal point off
    function automatic logic [SEG_W-1:0] digit_pattern(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] pat;
        case (digit)
            4'd0:    pat = 8'b11000000;
            4'd1:    pat = 8'b11111001;
            4'd2:    pat = 8'b10100100;
            4'd3:    pat = 8'b10110000;
            4'd4:    pat = 8'b10011001;
            4'd5:    pat = 8'b10010010;
            4'd6:    pat = 8'b10000010;
            4'd7:    pat = 8'b11111000;
            4'd8:    pat = 8'b10000000;
            4'd9:    pat = 8'b10010000;
            default: pat = 8'b11111111;
        endcase
        return pat;
    endfunction

endpackage

[hw/rtl/seven_segment_decimal_scan_unit.sv]
// Top level of the four-digit seven-segment decimal scan unit.
// Usage:
//   Input is a queue write port: drive i_value and raise push while full is
//   low; the item is taken on that edge. Each 16-bit value yields four column
//   items, thousands first, units last (o_last high). Output is a queue read
//   port: while empty is low the oldest item sits on o_column_enables,
//   o_segments and o_last; raising pop takes it.
//   Throughput: one column item per cycle while pop stays high and the
//   queue holds a record. The front end runs a single divide-by-ten
//   multiplier per value, and the back end writes one column per cycle
//   into its output register while it is not stalled by pop or the queue.
//   A small queue between them lets the front take the next value while the
//   back still scans the previous one.
//   Reset empties the queue and the output, and clears the segment latch to
//   zero, which blanked leading columns show until a column lights.
//   When pop stays low the output item holds, the back end stops, the queue
//   fills and full then rises; no item is dropped.
`timescale 1ns / 1ps
`include "seven_segment_decimal_scan_unit_macros.svh"

module seven_segment_decimal_scan_unit #(
    parameter int QUEUE_DEPTH = ssds_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  logic [ssds_pkg::VALUE_W-1:0]  i_value,
    output logic                          full,
    output logic                          empty,
    input  logic                          pop,
    output logic [ssds_pkg::COLS-1:0]     o_column_enables,
    output logic [ssds_pkg::SEG_W-1:0]    o_segments,
    output logic                          o_last
);

    logic                 w_q_push;
    logic                 w_q_full;
    logic                 w_q_pop;
    logic                 w_q_empty;
    ssds_pkg::t_digit_rec w_q_in;
    ssds_pkg::t_digit_rec w_q_head;

    // Digit extraction
    ssds_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_value  (i_value),
        .o_full   (full),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_rec  (w_q_in)
    );

    // Decoupling queue
    ssds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_rec   (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // Column scan
    ssds_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .i_q_head         (w_q_head),
        .o_q_pop          (w_q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_column_enables (o_column_enables),
        .o_segments       (o_segments),
        .o_last           (o_last)
    );

    // The units column always lights and alone
    `SSDS_ASSERT_NOW(a_units_lit, i_clk, i_rst_n, !empty && o_last, o_column_enables == 4'b0111)
    // A column item drives at most one column line low
    `SSDS_ASSERT_NOW(a_one_column, i_clk, i_rst_n, !empty, $countones(~o_column_enables) <= 1)
    // The front only finishes into a queue with room
    `SSDS_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, w_q_push, !w_q_full)
    // A record written without a read is visible next cycle
    `SSDS_ASSERT_NEXT(a_queue_fill, i_clk, i_rst_n, w_q_push && !w_q_pop, !w_q_empty)

endmodule

[hw/rtl/ssds_front.sv]
// Front end: accepts values, extracts four decimal digits and lit flags.
`timescale 1ns / 1ps

module ssds_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [ssds_pkg::VALUE_W-1:0] i_value,
    output logic                       o_full,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output ssds_pkg::t_digit_rec       o_q_rec
);

    logic                              r_busy;
    logic [ssds_pkg::COL_W-1:0]        r_step;
    logic [ssds_pkg::VALUE_W-1:0]      r_work;
    logic [ssds_pkg::COLS-1:0][ssds_pkg::DIGIT_W-1:0] r_digits;
    logic [ssds_pkg::COLS-1:0]         r_lit;

    logic [2*ssds_pkg::VALUE_W-1:0]    w_prod;
    logic [ssds_pkg::VALUE_W-1:0]      w_quot;
    logic [ssds_pkg::VALUE_W-1:0]      w_ten;
    logic [ssds_pkg::DIGIT_W-1:0]      w_rem;
    logic [ssds_pkg::COL_W-1:0]        w_col;
    logic                              w_last_step;
    logic                              w_accept;

    // One divide-by-ten per cycle, units digit first
    assign w_prod = {{ssds_pkg::VALUE_W{1'b0}}, r_work}
                  * {{ssds_pkg::VALUE_W{1'b0}}, ssds_pkg::DIV10_MUL};
    assign w_quot = ssds_pkg::VALUE_W'(w_prod >> ssds_pkg::DIV10_SHIFT);
    assign w_ten  = {w_quot[ssds_pkg::VALUE_W-4:0], 3'b000}
                  + {w_quot[ssds_pkg::VALUE_W-2:0], 1'b0};
    assign w_rem  = ssds_pkg::DIGIT_W'(r_work - w_ten);

    // Step s yields the digit of column 3 - s
    assign w_col       = ssds_pkg::UNITS_COL - r_step;
    assign w_last_step = (r_step == ssds_pkg::UNITS_COL);

    // Finish into the queue; a new item may enter on the finishing edge
    assign o_q_push = r_busy && w_last_step && !i_q_full;
    assign o_full   = r_busy && !o_q_push;
    assign w_accept = i_push && !o_full;

    // Thousands digit comes straight from the last remainder
    always_comb begin
        o_q_rec        = '0;
        o_q_rec.digits = r_digits;
        o_q_rec.digits[w_col] = w_rem;
        o_q_rec.lit    = r_lit;
    end

    // Control: busy flag and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (o_q_push) begin
            r_busy <= 1'b0;
        end else if (r_busy && !w_last_step) begin
            r_step <= r_step + 1'b1;
        end
    end

    // Datapath: load the value and classify, then shift digits out
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_work   <= i_value;
            r_lit[0] <= (i_value > ssds_pkg::THOUSANDS_MIN);
            r_lit[1] <= (i_value > ssds_pkg::HUNDREDS_MIN);
            r_lit[2] <= (i_value > ssds_pkg::TENS_MIN);
            r_lit[3] <= 1'b1;
        end else if (r_busy && !w_last_step) begin
            r_work          <= w_quot;
            r_digits[w_col] <= w_rem;
        end
    end

endmodule

[hw/rtl/ssds_queue.sv]
// Small first-in first-out queue of digit records between front and back.
`timescale 1ns / 1ps

module ssds_queue #(
    parameter int DEPTH = ssds_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ssds_pkg::t_digit_rec i_rec,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output ssds_pkg::t_digit_rec o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssds_pkg::t_digit_rec r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [CNT_W-1:0]     r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // Store incoming records
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/ssds_back.sv]
// Back end: scans the four columns of each record into the output register.
`timescale 1ns / 1ps

module ssds_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  ssds_pkg::t_digit_rec          i_q_head,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [ssds_pkg::COLS-1:0]     o_column_enables,
    output logic [ssds_pkg::SEG_W-1:0]    o_segments,
    output logic                          o_last
);

    logic [ssds_pkg::COL_W-1:0] r_col;
    logic [ssds_pkg::SEG_W-1:0] r_latch;
    logic                       r_out_valid;
    logic [ssds_pkg::COLS-1:0]  r_out_en;
    logic [ssds_pkg::SEG_W-1:0] r_out_seg;
    logic                       r_out_last;

    logic                       w_load;
    logic                       w_lit;
    logic [ssds_pkg::SEG_W-1:0] n_latch;
    logic [ssds_pkg::COLS-1:0]  n_out_en;

    // Load a column when the output register is free or being taken
    assign w_load  = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = w_load && (r_col == ssds_pkg::UNITS_COL);

    // A lit column reloads the latch and pulls its own line low
    always_comb begin
        w_lit = i_q_head.lit[r_col];
        if (w_lit) begin
            n_latch  = ssds_pkg::digit_pattern(i_q_head.digits[r_col]);
            n_out_en = ~(ssds_pkg::COLS'(1) << r_col);
        end else begin
            n_latch  = r_latch;
            n_out_en = ssds_pkg::ALL_COLUMNS_OFF;
        end
    end

    // Control: column counter, latch and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_latch     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_col       <= r_col + 1'b1;
            r_latch     <= n_latch;
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_en   <= n_out_en;
            r_out_seg  <= n_latch;
            r_out_last <= (r_col == ssds_pkg::UNITS_COL);
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_column_enables = r_out_en;
    assign o_segments       = r_out_seg;
    assign o_last           = r_out_last;

endmodule
